// ===== hw/rtl/lcs_pkg.sv =====
// Shared types and constants for the loop chunk scheduler.
// Holds payload structs, configuration codes, opcodes and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package lcs_pkg;

  // Input item opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_SCHED_MODE   = 2'd0;
  localparam logic [1:0] CFG_BASE_CHUNK   = 2'd1;
  localparam logic [1:0] CFG_WORKER_COUNT = 2'd2;

  // Chunk sizing modes (the unused code behaves as dynamic)
  localparam logic [1:0] MODE_STATIC  = 2'd0;
  localparam logic [1:0] MODE_DYNAMIC = 2'd1;
  localparam logic [1:0] MODE_GUIDED  = 2'd2;

  // Register reset values and limits
  localparam logic [1:0] SCHED_MODE_RESET   = MODE_STATIC;
  localparam logic [7:0] BASE_CHUNK_RESET   = 8'd2;
  localparam logic [4:0] WORKER_COUNT_RESET = 5'd4;
  localparam logic [4:0] MAX_WORKERS        = 5'd16;

  typedef struct packed {
    logic        opcode;
    logic [15:0] iteration_count;
  } lcs_in_t;

  typedef struct packed {
    logic [15:0] chunk_start;
    logic [15:0] chunk_length;
    logic [3:0]  worker_index;
    logic        done_res;
  } lcs_out_t;

  // Status of the serial divider
  typedef struct packed {
    logic busy;
    logic done;
  } lcs_div_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_DIVIDE,
    ST_CALC,
    ST_FINISH
  } lcs_state_t;

endpackage

// ===== hw/rtl/lcs_divider.sv =====
// Restoring bit-serial divider: a COUNT_WIDTH-bit dividend by a divisor of 1 to 16.
// One quotient bit per cycle. Uses lcs_pkg for its status struct.
`timescale 1ns / 1ps

module lcs_divider #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [COUNT_WIDTH-1:0]    dividend,
  input  logic [4:0]                divisor,
  output logic [COUNT_WIDTH-1:0]    quotient,
  output logic [4:0]                remainder,
  output lcs_pkg::lcs_div_stat_t    stat
);

  localparam int CNT_W = (COUNT_WIDTH > 1) ? $clog2(COUNT_WIDTH) : 1;

  logic [COUNT_WIDTH-1:0] quo;
  logic [4:0]             part;
  logic [CNT_W-1:0]       cnt;
  logic                   busy;
  logic                   done;
  logic [4:0]             trial;
  logic                   fits;

  // Shift the next dividend bit into the partial remainder and try the subtract
  always_comb begin
    trial = {part[3:0], quo[COUNT_WIDTH-1]};
    fits  = (trial >= divisor);
  end

  // Control: busy until every dividend bit has been shifted through, then pulse done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(COUNT_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      part <= '0;
    end else if (busy) begin
      quo  <= {quo[COUNT_WIDTH-2:0], fits};
      part <= fits ? (trial - divisor) : trial;
    end
  end

  assign quotient  = quo;
  assign remainder = part;
  assign stat      = '{busy: busy, done: done};

endmodule

// ===== hw/rtl/loop_chunk_scheduler.sv =====
// Loop chunk scheduler top level: register file, sequencer and chunk sizing.
// Depends on lcs_pkg and lcs_divider.
//
//   channel   direction  payload            handshake
//   in        into block lcs_in_t (in_data)  in_valid / in_ready
//   out       from block lcs_out_t (out_data) out_valid / out_ready
//   cfg       into block cfg_index, cfg_data cfg_we, no back-pressure
//
// A start item loads the loop and gives no result. A next item passes through
// rotor reduction, the bit-serial divider (one quotient bit a cycle), length
// calculation and finish; reduction repeats when the worker rotor must be reduced
// after a worker count change. An exhausted loop skips the divider.
// Synchronous reset clears the loop state and loads the register defaults.
// A waiting result is held in the output register; the next item is accepted
// meanwhile, and a finished chunk stalls only until that register frees.
`timescale 1ns / 1ps

module loop_chunk_scheduler #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lcs_pkg::lcs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lcs_pkg::lcs_out_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data
);

  localparam int CMP_W = (COUNT_WIDTH > 13) ? COUNT_WIDTH : 13;

  lcs_pkg::lcs_state_t state, state_next;

  logic [1:0]             sched_mode;
  logic [7:0]             base_chunk;
  logic [4:0]             worker_count;
  logic [COUNT_WIDTH-1:0] remaining_iters;
  logic [COUNT_WIDTH-1:0] next_start;
  logic [3:0]             worker_rotor;
  logic [3:0]             rot;
  logic [COUNT_WIDTH-1:0] len;

  logic [4:0]             w_eff;
  logic [7:0]             c_eff;
  logic                   in_xfer;
  logic                   out_free;
  logic                   rot_big;
  logic                   div_start;
  logic                   load_res;
  logic [COUNT_WIDTH-1:0] quotient;
  logic [4:0]             remainder;
  lcs_pkg::lcs_div_stat_t div_stat;

  logic [12:0]            cw;
  logic [CMP_W-1:0]       c_ext, rem_ext, q_ext, cw_ext, ceil_ext, len_raw, len_clip;
  logic [4:0]             rot_inc;
  logic [31:0]            start_wide, len_wide;

  // Effective worker count and chunk size
  always_comb begin
    if (worker_count == 5'd0) begin
      w_eff = 5'd1;
    end else if (worker_count > lcs_pkg::MAX_WORKERS) begin
      w_eff = lcs_pkg::MAX_WORKERS;
    end else begin
      w_eff = worker_count;
    end
    c_eff = (base_chunk == 8'd0) ? 8'd1 : base_chunk;
  end

  assign in_ready = (state == lcs_pkg::ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign rot_big  = ({1'b0, rot} >= w_eff);

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      sched_mode   <= lcs_pkg::SCHED_MODE_RESET;
      base_chunk   <= lcs_pkg::BASE_CHUNK_RESET;
      worker_count <= lcs_pkg::WORKER_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lcs_pkg::CFG_SCHED_MODE:   sched_mode   <= cfg_data[1:0];
        lcs_pkg::CFG_BASE_CHUNK:   base_chunk   <= cfg_data;
        lcs_pkg::CFG_WORKER_COUNT: worker_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      lcs_pkg::ST_IDLE: begin
        if (in_xfer && in_data.opcode == lcs_pkg::OP_NEXT) state_next = lcs_pkg::ST_REDUCE;
      end
      lcs_pkg::ST_REDUCE: begin
        if (!rot_big) begin
          state_next = (remaining_iters == '0) ? lcs_pkg::ST_FINISH : lcs_pkg::ST_DIVIDE;
        end
      end
      lcs_pkg::ST_DIVIDE: begin
        if (div_stat.done) state_next = lcs_pkg::ST_CALC;
      end
      lcs_pkg::ST_CALC:   state_next = lcs_pkg::ST_FINISH;
      lcs_pkg::ST_FINISH: begin
        if (out_free) state_next = lcs_pkg::ST_IDLE;
      end
      default: state_next = lcs_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    div_start = 1'b0;
    load_res  = 1'b0;
    case (state)
      lcs_pkg::ST_REDUCE: div_start = !rot_big && (remaining_iters != '0);
      lcs_pkg::ST_FINISH: load_res  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= lcs_pkg::ST_IDLE;
    else     state <= state_next;
  end

  lcs_divider #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (remaining_iters),
    .divisor  (w_eff),
    .quotient (quotient),
    .remainder(remainder),
    .stat     (div_stat)
  );

  // Chunk length by mode, from the base chunk or the quotient, then clip to what is left
  always_comb begin
    cw       = 13'(c_eff) * 13'(w_eff);
    c_ext    = CMP_W'(c_eff);
    rem_ext  = CMP_W'(remaining_iters);
    q_ext    = CMP_W'(quotient);
    cw_ext   = CMP_W'(cw);
    ceil_ext = q_ext + CMP_W'(remainder != 5'd0);
    case (sched_mode)
      lcs_pkg::MODE_STATIC: begin
        if (cw_ext < rem_ext)     len_raw = c_ext;
        else if (q_ext == '0)     len_raw = rem_ext;
        else                      len_raw = q_ext;
      end
      lcs_pkg::MODE_GUIDED: begin
        len_raw = (q_ext < c_ext) ? c_ext : ceil_ext;
      end
      default: len_raw = c_ext;
    endcase
    len_clip = (len_raw > rem_ext) ? rem_ext : len_raw;
  end

  assign rot_inc    = {1'b0, rot} + 5'd1;
  assign start_wide = 32'(next_start);
  assign len_wide   = 32'(len);

  // Rotor reduction, length capture and loop state update
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining_iters <= '0;
      next_start      <= '0;
      worker_rotor    <= '0;
    end else if (in_xfer && in_data.opcode == lcs_pkg::OP_START) begin
      remaining_iters <= COUNT_WIDTH'(in_data.iteration_count);
      next_start      <= '0;
      worker_rotor    <= '0;
    end else if (load_res && remaining_iters != '0) begin
      remaining_iters <= remaining_iters - len;
      next_start      <= next_start + len;
      worker_rotor    <= (rot_inc == w_eff) ? 4'd0 : rot_inc[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rot <= worker_rotor;
    end else if (state == lcs_pkg::ST_REDUCE && rot_big) begin
      rot <= 4'(({1'b0, rot} - w_eff));
    end
    if (state == lcs_pkg::ST_CALC) len <= COUNT_WIDTH'(len_clip);
  end

  // Output register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_res) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      out_data.chunk_start  <= start_wide[15:0];
      out_data.chunk_length <= (remaining_iters == '0) ? 16'd0 : len_wide[15:0];
      out_data.worker_index <= rot;
      out_data.done_res     <= (remaining_iters == '0);
    end
  end

  // The divider runs only while the sequencer waits on it
  a_div_in_divide: assert property (@(posedge clk) disable iff (rst)
    (div_stat.busy || div_stat.done) |-> state == lcs_pkg::ST_DIVIDE)
    else $error("divider active outside the divide state");

  // The rotor is reduced below the worker count before sizing
  a_rot_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == lcs_pkg::ST_CALC || state == lcs_pkg::ST_FINISH) |-> ({1'b0, rot} < w_eff))
    else $error("worker rotor not reduced");

  // A handed-out chunk always shrinks the remaining count
  a_progress: assert property (@(posedge clk) disable iff (rst)
    (load_res && remaining_iters != '0) |=> remaining_iters < $past(remaining_iters))
    else $error("chunk handed out without progress");

  // A next item leaves idle for rotor reduction
  a_next_starts: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && in_data.opcode == lcs_pkg::OP_NEXT) |=> state == lcs_pkg::ST_REDUCE)
    else $error("next item not taken up");

  // A done result carries no iterations
  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    (load_res && remaining_iters == '0) |=> (out_data.done_res && out_data.chunk_length == 16'd0))
    else $error("done result with nonzero length");

endmodule
